@@ design/qes_pkg.sv @@
// Shared constants, types and tables of the quaternion to Euler angle smoother.
package qes_pkg;

	// Block configuration
	localparam int WINDOW_SIZE     = 3;
	localparam int ANGLE_FRAC_BITS = 15;
	localparam int SLOT_W          = $clog2(WINDOW_SIZE);
	localparam int FILL_W          = $clog2(WINDOW_SIZE + 1);
	localparam int UNIT_SHIFT      = 30 - ANGLE_FRAC_BITS;

	// Field widths
	localparam int QUAT_W     = 16;
	localparam int ANG_W      = 18;
	localparam int PITCH_W    = 17;
	localparam int MAX_STEP_W = 17;
	localparam int CFG_IDX_W  = 2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_RAW_MODE       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PITCH_STEP = 2'd1;
	localparam logic [MAX_STEP_W-1:0] MAX_STEP_RESET    = 17'd572;

	// CORDIC datapath
	localparam int OPND_W       = 35;
	localparam int CORDIC_W     = 44;
	localparam int Z_W          = 34;
	localparam int CORDIC_STEPS = 31;
	localparam int STEP_W       = $clog2(CORDIC_STEPS);
	localparam longint PI_Q30      = 64'sd3373259426;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint PI_UNITS_L  =
		(PI_Q30 + (64'sd1 <<< (UNIT_SHIFT - 1))) >>> UNIT_SHIFT;
	localparam logic signed [Z_W-1:0] PI_Z       = Z_W'(PI_Q30);
	localparam logic signed [Z_W-1:0] HALF_PI_Z  = Z_W'(HALF_PI_Q30);
	localparam logic signed [Z_W-1:0] ROUND_HALF = Z_W'(64'sd1 <<< (UNIT_SHIFT - 1));
	localparam logic signed [CORDIC_W-1:0] NORM_COARSE = CORDIC_W'(64'sd1 <<< 31);
	localparam logic signed [CORDIC_W-1:0] NORM_TARGET = CORDIC_W'(64'sd1 <<< 39);
	localparam int NORM_COARSE_SHIFT = 8;

	// Window average: sum width and reciprocal for the divide by the window size
	localparam int SUM_W     = ANG_W + 2 + $clog2(WINDOW_SIZE);
	localparam int DIV_K     = 24;
	localparam longint DIV_RECIP =
		((64'sd1 <<< DIV_K) + 2 * WINDOW_SIZE - 1) / (2 * WINDOW_SIZE);

	localparam int QUEUE_DEPTH = 2;

	typedef logic signed [OPND_W-1:0] opnd_t;
	typedef logic signed [ANG_W-1:0]  angle_t;

	localparam angle_t PI_UNITS      = ANG_W'(PI_UNITS_L);
	localparam angle_t HALF_PI_UNITS = ANG_W'(PI_UNITS_L >>> 1);

	// atan2 operand pairs of one sample, y before x
	typedef struct packed {
		opnd_t roll_y;
		opnd_t roll_x;
		opnd_t yaw_y;
		opnd_t yaw_x;
		opnd_t pitch_y;
		opnd_t pitch_x;
	} work_t;

	// atan(2^-i) in Q30 radians, truncated
	function automatic logic signed [31:0] cordic_angle(input logic [STEP_W-1:0] i);
		logic signed [31:0] a;
		case (i)
			5'd0:  a = 32'sh3243F6A8;
			5'd1:  a = 32'sh1DAC6705;
			5'd2:  a = 32'sh0FADBAFC;
			5'd3:  a = 32'sh07F56EA6;
			5'd4:  a = 32'sh03FEAB76;
			5'd5:  a = 32'sh01FFD55B;
			5'd6:  a = 32'sh00FFFAAA;
			5'd7:  a = 32'sh007FFF55;
			5'd8:  a = 32'sh003FFFEA;
			5'd9:  a = 32'sh001FFFFD;
			5'd10: a = 32'sh000FFFFF;
			5'd11: a = 32'sh0007FFFF;
			5'd12: a = 32'sh0003FFFF;
			5'd13: a = 32'sh0001FFFF;
			5'd14: a = 32'sh0000FFFF;
			5'd15: a = 32'sh00007FFF;
			5'd16: a = 32'sh00003FFF;
			5'd17: a = 32'sh00001FFF;
			5'd18: a = 32'sh00000FFF;
			5'd19: a = 32'sh000007FF;
			5'd20: a = 32'sh000003FF;
			5'd21: a = 32'sh000001FF;
			5'd22: a = 32'sh000000FF;
			5'd23: a = 32'sh0000007F;
			5'd24: a = 32'sh0000003F;
			5'd25: a = 32'sh0000001F;
			5'd26: a = 32'sh0000000F;
			5'd27: a = 32'sh00000008;
			5'd28: a = 32'sh00000004;
			5'd29: a = 32'sh00000002;
			5'd30: a = 32'sh00000001;
			default: a = 32'sh00000000;
		endcase
		return a;
	endfunction

endpackage

@@ design/qes_if.sv @@
// Channel interfaces: quaternion input, Euler angle output, register writes.
interface qes_quat_if;
	logic valid;
	logic ready;
	logic signed [qes_pkg::QUAT_W-1:0] quat_w;
	logic signed [qes_pkg::QUAT_W-1:0] quat_x;
	logic signed [qes_pkg::QUAT_W-1:0] quat_y;
	logic signed [qes_pkg::QUAT_W-1:0] quat_z;
	modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
	modport sink (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qes_euler_if;
	logic valid;
	logic ready;
	logic signed [qes_pkg::ANG_W-1:0]   yaw_angle;
	logic signed [qes_pkg::PITCH_W-1:0] pitch_angle;
	logic signed [qes_pkg::ANG_W-1:0]   roll_angle;
	modport source (output valid, yaw_angle, pitch_angle, roll_angle, input ready);
	modport sink (input valid, yaw_angle, pitch_angle, roll_angle, output ready);
endinterface

interface qes_cfg_if;
	logic valid;
	logic ready;
	logic [qes_pkg::CFG_IDX_W-1:0]  index;
	logic [qes_pkg::MAX_STEP_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ design/quaternion_euler_smoother_unit.sv @@
// Top level of the quaternion to Euler angle smoother.
// Each quat transaction carries one orientation quaternion (w, x, y, z, any
// common scale). The block derives roll, pitch and yaw in signed units of
// 2^-15 radian: roll and yaw in [-pi, pi], pitch in [-pi/2, pi/2] with the
// asin input saturated to +-1. An all-zero quaternion is dropped and yields
// no euler transaction. With raw_mode = 1 every sample gives one result at
// once. With raw_mode = 0 samples fill a three-deep window; the first three
// samples give no result, every later one gives the window average, with yaw
// unwrapped around the newest sample and rewrapped into [-pi, pi], and with
// pitch moving at most max_pitch_step per result (the first smoothed pitch
// is taken as is). Registers: index 0 raw_mode (reset 0), index 1
// max_pitch_step (reset 572); write them only while the block is idle. The
// cfg channel is always ready. The front does ten shared 16x16 multiplies
// plus a 32-step bit-by-bit square root; the back runs three CORDIC lanes in
// parallel, a few normalizing shifts and 31 iterations each, then the window
// arithmetic (ring, sum, divide and output steps). A two-entry queue lets
// both halves overlap, so the front can take a new sample while the back is
// still working on an earlier one. A finished result waits in the output
// register while the next item is already being worked on.
module quaternion_euler_smoother_unit (
	input  logic         clk,
	input  logic         arst_n,
	qes_quat_if.sink     quat,
	qes_cfg_if.sink      cfg,
	qes_euler_if.source  euler
);
	import qes_pkg::*;

	logic                  raw_mode_q;
	logic [MAX_STEP_W-1:0] max_pitch_step_q;
	logic                  push_valid, push_ready, pop_valid, pop_ready;
	work_t                 push_data, pop_data;

	// register file: always take the write
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_mode_q       <= 1'b0;
			max_pitch_step_q <= MAX_STEP_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_RAW_MODE:       raw_mode_q       <= cfg.data[0];
				CFG_MAX_PITCH_STEP: max_pitch_step_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// front: accept, classify, products and square root
	qes_front u_front (
		.clk(clk), .arst_n(arst_n), .quat(quat),
		.push_valid(push_valid), .push_ready(push_ready), .push_data(push_data)
	);

	// decouple the two halves
	qes_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push_valid(push_valid), .push_ready(push_ready), .push_data(push_data),
		.pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data)
	);

	// back: angles, window, limit and the output register
	qes_back u_back (
		.clk(clk), .arst_n(arst_n),
		.pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data),
		.raw_mode(raw_mode_q), .max_pitch_step(max_pitch_step_q), .euler(euler)
	);

endmodule

@@ design/qes_queue.sv @@
// Short work queue between the front and the back.
module qes_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  qes_pkg::work_t  push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output qes_pkg::work_t  pop_data
);
	import qes_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	work_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push, do_pop;

	assign push_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

endmodule

@@ design/qes_front.sv @@
// Front: accepts a quaternion, forms products, drops zero, square root for pitch.
module qes_front (
	input  logic           clk,
	input  logic           arst_n,
	qes_quat_if.sink       quat,
	output logic           push_valid,
	input  logic           push_ready,
	output qes_pkg::work_t push_data
);
	import qes_pkg::*;

	typedef enum logic [2:0] {F_IDLE, F_MUL, F_SUM, F_PMUL, F_SQRT, F_PUSH} fstate_t;

	localparam int MUL_COUNT = 10;
	localparam int MCNT_W    = $clog2(MUL_COUNT);
	localparam logic [MCNT_W-1:0] P_WW = 4'd0, P_XX = 4'd1, P_YY = 4'd2, P_ZZ = 4'd3,
		P_YZ = 4'd4, P_WX = 4'd5, P_XY = 4'd6, P_WZ = 4'd7, P_XZ = 4'd8, P_WY = 4'd9;
	localparam int SQRT_STEPS = 32;
	localparam int SCNT_W     = $clog2(SQRT_STEPS);

	fstate_t                   state_q;
	logic [MCNT_W-1:0]         mcnt_q;
	logic [SCNT_W-1:0]         scnt_q;
	logic signed [QUAT_W-1:0]  w_q, x_q, y_q, z_q;
	logic signed [QUAT_W-1:0]  ma, mb;
	logic signed [31:0]        prod_c;
	logic signed [31:0]        prod_q [MUL_COUNT];
	logic signed [33:0]        n_c, m_c, absm_c, am_w;
	logic signed [33:0]        roll_y_c, roll_x_c, yaw_y_c, yaw_x_c;
	logic [31:0]               nn_c, am_c;
	logic signed [32:0]        sm_c;
	opnd_t                     roll_y_q, roll_x_q, yaw_y_q, yaw_x_q, pitch_y_q;
	logic [31:0]               nn_q, am_q;
	logic [32:0]               dif_c, add_c;
	logic [65:0]               rad_full_c;
	logic [63:0]               rad_q, res_q, bit_q, sqsum_c;

	assign quat.ready = (state_q == F_IDLE);
	assign push_valid = (state_q == F_PUSH);

	always_comb begin
		case (mcnt_q)
			P_WW: begin ma = w_q; mb = w_q; end
			P_XX: begin ma = x_q; mb = x_q; end
			P_YY: begin ma = y_q; mb = y_q; end
			P_ZZ: begin ma = z_q; mb = z_q; end
			P_YZ: begin ma = y_q; mb = z_q; end
			P_WX: begin ma = w_q; mb = x_q; end
			P_XY: begin ma = x_q; mb = y_q; end
			P_WZ: begin ma = w_q; mb = z_q; end
			P_XZ: begin ma = x_q; mb = z_q; end
			P_WY: begin ma = w_q; mb = y_q; end
			default: begin ma = '0; mb = '0; end
		endcase
		prod_c = ma * mb;
	end

	always_comb begin
		n_c      = 34'(prod_q[P_WW]) + 34'(prod_q[P_XX]) + 34'(prod_q[P_YY])
			+ 34'(prod_q[P_ZZ]);
		roll_y_c = (34'(prod_q[P_YZ]) - 34'(prod_q[P_WX])) <<< 1;
		roll_x_c = 34'(prod_q[P_WW]) - 34'(prod_q[P_XX]) - 34'(prod_q[P_YY])
			+ 34'(prod_q[P_ZZ]);
		yaw_y_c  = (34'(prod_q[P_XY]) - 34'(prod_q[P_WZ])) <<< 1;
		yaw_x_c  = 34'(prod_q[P_WW]) + 34'(prod_q[P_XX]) - 34'(prod_q[P_YY])
			- 34'(prod_q[P_ZZ]);
		m_c      = (34'(prod_q[P_XZ]) + 34'(prod_q[P_WY])) <<< 1;
		absm_c   = (m_c < 0) ? -m_c : m_c;
		// scale down large norms by one bit, then saturate the asin input
		if (n_c >= 34'sd2147483648) begin
			nn_c = n_c[32:1];
			am_w = absm_c >>> 1;
		end else begin
			nn_c = n_c[31:0];
			am_w = absm_c;
		end
		am_c = (am_w > 34'(nn_c)) ? nn_c : am_w[31:0];
		sm_c = (m_c < 0) ? signed'({1'b0, am_c}) : -signed'({1'b0, am_c});
	end

	always_comb begin
		dif_c      = {1'b0, nn_q} - {1'b0, am_q};
		add_c      = {1'b0, nn_q} + {1'b0, am_q};
		rad_full_c = dif_c * add_c;
		sqsum_c    = res_q + bit_q;
	end

	always_comb begin
		push_data.roll_y  = roll_y_q;
		push_data.roll_x  = roll_x_q;
		push_data.yaw_y   = yaw_y_q;
		push_data.yaw_x   = yaw_x_q;
		push_data.pitch_y = pitch_y_q;
		push_data.pitch_x = OPND_W'({1'b0, res_q[32:0]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			mcnt_q  <= '0;
			scnt_q  <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (quat.valid) begin
						mcnt_q  <= '0;
						state_q <= F_MUL;
					end
				end
				F_MUL: begin
					mcnt_q <= mcnt_q + 1'b1;
					if (mcnt_q == MCNT_W'(MUL_COUNT - 1)) begin
						state_q <= F_SUM;
					end
				end
				F_SUM: begin
					// drop an all-zero quaternion
					state_q <= (n_c == '0) ? F_IDLE : F_PMUL;
				end
				F_PMUL: begin
					scnt_q  <= '0;
					state_q <= F_SQRT;
				end
				F_SQRT: begin
					scnt_q <= scnt_q + 1'b1;
					if (scnt_q == SCNT_W'(SQRT_STEPS - 1)) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (push_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && quat.valid) begin
			w_q <= quat.quat_w;
			x_q <= quat.quat_x;
			y_q <= quat.quat_y;
			z_q <= quat.quat_z;
		end
		if (state_q == F_MUL) begin
			prod_q[mcnt_q] <= prod_c;
		end
		if (state_q == F_SUM) begin
			roll_y_q  <= OPND_W'(roll_y_c);
			roll_x_q  <= OPND_W'(roll_x_c);
			yaw_y_q   <= OPND_W'(yaw_y_c);
			yaw_x_q   <= OPND_W'(yaw_x_c);
			pitch_y_q <= OPND_W'(sm_c);
			nn_q      <= nn_c;
			am_q      <= am_c;
		end
		if (state_q == F_PMUL) begin
			rad_q <= rad_full_c[63:0];
			res_q <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end
		if (state_q == F_SQRT) begin
			// one result bit per step of the floor square root
			if (rad_q >= sqsum_c) begin
				rad_q <= rad_q - sqsum_c;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

endmodule

@@ design/qes_cordic.sv @@
// Iterative vectoring CORDIC atan2 with rounding to angle units.
module qes_cordic (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  qes_pkg::opnd_t  y_in,
	input  qes_pkg::opnd_t  x_in,
	output logic            done,
	output qes_pkg::angle_t angle
);
	import qes_pkg::*;

	typedef enum logic [1:0] {C_IDLE, C_NORM, C_ITER, C_FIN} cstate_t;

	cstate_t                     state_q;
	logic                        done_q;
	angle_t                      angle_q;
	logic [STEP_W-1:0]           it_q;
	logic signed [CORDIC_W-1:0]  x_q, y_q, absy_c, mx_c, dx_c, dy_c;
	logic signed [Z_W-1:0]       z_q, ang_c, rnd_c, units_c;

	assign done  = done_q;
	assign angle = angle_q;

	always_comb begin
		absy_c  = (y_q < 0) ? -y_q : y_q;
		mx_c    = (x_q > absy_c) ? x_q : absy_c;
		dx_c    = y_q >>> it_q;
		dy_c    = x_q >>> it_q;
		ang_c   = Z_W'(cordic_angle(it_q));
		rnd_c   = z_q + ROUND_HALF;
		units_c = rnd_c >>> UNIT_SHIFT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			done_q  <= 1'b0;
			angle_q <= '0;
			it_q    <= '0;
		end else begin
			case (state_q)
				C_IDLE: begin
					if (start) begin
						done_q <= 1'b0;
						it_q   <= '0;
						if (y_in == '0 || x_in == '0) begin
							state_q <= C_FIN;
						end else begin
							state_q <= C_NORM;
						end
					end
				end
				C_NORM: begin
					if (mx_c >= NORM_TARGET) begin
						state_q <= C_ITER;
					end
				end
				C_ITER: begin
					it_q <= it_q + 1'b1;
					if (it_q == STEP_W'(CORDIC_STEPS - 1)) begin
						state_q <= C_FIN;
					end
				end
				C_FIN: begin
					if (units_c > Z_W'(PI_UNITS)) begin
						angle_q <= PI_UNITS;
					end else if (units_c < -Z_W'(PI_UNITS)) begin
						angle_q <= -PI_UNITS;
					end else begin
						angle_q <= ANG_W'(units_c);
					end
					done_q  <= 1'b1;
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == C_IDLE && start) begin
			if (y_in == '0) begin
				z_q <= (x_in < 0) ? PI_Z : '0;
			end else if (x_in == '0) begin
				z_q <= (y_in > 0) ? HALF_PI_Z : -HALF_PI_Z;
			end else if (x_in < 0) begin
				// fold into the right half plane, keep the offset in z
				z_q <= (y_in > 0) ? PI_Z : -PI_Z;
				x_q <= -CORDIC_W'(x_in);
				y_q <= -CORDIC_W'(y_in);
			end else begin
				z_q <= '0;
				x_q <= CORDIC_W'(x_in);
				y_q <= CORDIC_W'(y_in);
			end
		end
		if (state_q == C_NORM) begin
			if (mx_c < NORM_COARSE) begin
				x_q <= x_q <<< NORM_COARSE_SHIFT;
				y_q <= y_q <<< NORM_COARSE_SHIFT;
			end else if (mx_c < NORM_TARGET) begin
				x_q <= x_q <<< 1;
				y_q <= y_q <<< 1;
			end
		end
		if (state_q == C_ITER) begin
			if (y_q > 0) begin
				x_q <= x_q + dx_c;
				y_q <= y_q - dy_c;
				z_q <= z_q + ang_c;
			end else begin
				x_q <= x_q - dx_c;
				y_q <= y_q + dy_c;
				z_q <= z_q - ang_c;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == C_ITER) |-> (mx_c >= NORM_TARGET || it_q != '0))
		else $error("CORDIC iterations entered with an unnormalized vector");

endmodule

@@ design/qes_back.sv @@
// Back: three CORDIC lanes, sample window, yaw unwrap, pitch slew limit, output.
module qes_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               pop_valid,
	output logic                               pop_ready,
	input  qes_pkg::work_t                     pop_data,
	input  logic                               raw_mode,
	input  logic [qes_pkg::MAX_STEP_W-1:0]     max_pitch_step,
	qes_euler_if.source                        euler
);
	import qes_pkg::*;

	typedef enum logic [2:0] {B_IDLE, B_WAIT, B_RING, B_SUM, B_DIV, B_FIN} bstate_t;

	localparam int PROD_W = SUM_W + DIV_K + 1;
	typedef logic signed [SUM_W-1:0] sum_t;

	localparam sum_t PI_S     = SUM_W'(PI_UNITS);
	localparam sum_t TWO_PI_S = SUM_W'(PI_UNITS) <<< 1;

	bstate_t              state_q;
	logic                 start;
	logic [2:0]           done;
	angle_t               roll_a, yaw_a, pitch_a;
	logic                 raw_q;
	logic [SLOT_W-1:0]    slot_q, next_slot;
	logic [FILL_W-1:0]    fill_q;
	angle_t               held_q;
	logic                 known_q;
	angle_t               ring_roll_q [WINDOW_SIZE];
	angle_t               ring_pitch_q [WINDOW_SIZE];
	angle_t               ring_yaw_q [WINDOW_SIZE];
	sum_t                 rs_q, ps_q, ys_q, rs_c, ps_c, ys_c;
	sum_t                 mroll_q, mpitch_q, myaw_q;
	sum_t                 newest_c, v_c, d_c;
	sum_t                 yaw_wrap_c, held_ext_c, step_c, lo_c, hi_c, np_c;
	logic                 out_valid_q, out_free;
	angle_t               out_yaw_q, out_roll_q;
	logic signed [PITCH_W-1:0] out_pitch_q;
	angle_t               fin_yaw, fin_roll, fin_pitch;

	function automatic sum_t div_window(input sum_t v);
		logic [SUM_W-1:0]  mag;
		logic [SUM_W:0]    t;
		logic [PROD_W-1:0] p;
		logic [SUM_W-1:0]  q;
		mag = (v < 0) ? SUM_W'(-v) : SUM_W'(v);
		t   = ({1'b0, mag} << 1) + (SUM_W + 1)'(WINDOW_SIZE);
		p   = PROD_W'(t) * PROD_W'(DIV_RECIP);
		q   = p[DIV_K +: SUM_W];
		return (v < 0) ? -signed'(q) : signed'(q);
	endfunction

	assign pop_ready = (state_q == B_IDLE);
	assign start     = pop_valid && (state_q == B_IDLE);
	assign next_slot = (slot_q == SLOT_W'(WINDOW_SIZE - 1)) ? '0 : slot_q + 1'b1;
	assign out_free  = !out_valid_q || euler.ready;

	assign euler.valid       = out_valid_q;
	assign euler.yaw_angle   = out_yaw_q;
	assign euler.pitch_angle = out_pitch_q;
	assign euler.roll_angle  = out_roll_q;

	qes_cordic u_roll (
		.clk(clk), .arst_n(arst_n), .start(start),
		.y_in(pop_data.roll_y), .x_in(pop_data.roll_x), .done(done[0]), .angle(roll_a)
	);
	qes_cordic u_yaw (
		.clk(clk), .arst_n(arst_n), .start(start),
		.y_in(pop_data.yaw_y), .x_in(pop_data.yaw_x), .done(done[1]), .angle(yaw_a)
	);
	qes_cordic u_pitch (
		.clk(clk), .arst_n(arst_n), .start(start),
		.y_in(pop_data.pitch_y), .x_in(pop_data.pitch_x), .done(done[2]),
		.angle(pitch_a)
	);

	// window sums, older yaw samples unwrapped around the newest one
	always_comb begin
		rs_c     = '0;
		ps_c     = '0;
		ys_c     = '0;
		newest_c = SUM_W'(ring_yaw_q[slot_q]);
		for (int j = 0; j < WINDOW_SIZE; j++) begin
			rs_c = rs_c + SUM_W'(ring_roll_q[j]);
			ps_c = ps_c + SUM_W'(ring_pitch_q[j]);
			v_c  = SUM_W'(ring_yaw_q[j]);
			d_c  = newest_c - v_c;
			if (SLOT_W'(j) != slot_q && (d_c > PI_S || d_c < -PI_S)) begin
				v_c = (newest_c > 0) ? v_c + TWO_PI_S : v_c - TWO_PI_S;
			end
			ys_c = ys_c + v_c;
		end
	end

	always_comb begin
		if (myaw_q > PI_S) begin
			yaw_wrap_c = myaw_q - TWO_PI_S;
		end else if (myaw_q < -PI_S) begin
			yaw_wrap_c = myaw_q + TWO_PI_S;
		end else begin
			yaw_wrap_c = myaw_q;
		end
		held_ext_c = SUM_W'(held_q);
		step_c     = signed'(SUM_W'(max_pitch_step));
		lo_c       = held_ext_c - step_c;
		hi_c       = held_ext_c + step_c;
		if (!known_q) begin
			np_c = mpitch_q;
		end else if (mpitch_q < held_ext_c) begin
			np_c = (mpitch_q > lo_c) ? mpitch_q : lo_c;
		end else if (mpitch_q > held_ext_c) begin
			np_c = (mpitch_q < hi_c) ? mpitch_q : hi_c;
		end else begin
			np_c = held_ext_c;
		end
		if (raw_q) begin
			fin_yaw   = yaw_a;
			fin_roll  = roll_a;
			fin_pitch = pitch_a;
		end else begin
			fin_yaw   = ANG_W'(yaw_wrap_c);
			fin_roll  = ANG_W'(mroll_q);
			fin_pitch = ANG_W'(np_c);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			raw_q       <= 1'b0;
			slot_q      <= SLOT_W'(WINDOW_SIZE - 1);
			fill_q      <= '0;
			held_q      <= '0;
			known_q     <= 1'b0;
			out_valid_q <= 1'b0;
			out_yaw_q   <= '0;
			out_pitch_q <= '0;
			out_roll_q  <= '0;
		end else begin
			// B_FIN reloads the output register itself
			if (out_valid_q && euler.ready && state_q != B_FIN) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (pop_valid) begin
						state_q <= B_WAIT;
					end
				end
				B_WAIT: begin
					if (&done) begin
						raw_q   <= raw_mode;
						state_q <= raw_mode ? B_FIN : B_RING;
					end
				end
				B_RING: begin
					slot_q <= next_slot;
					if (fill_q < FILL_W'(WINDOW_SIZE)) begin
						fill_q  <= fill_q + 1'b1;
						state_q <= B_IDLE;
					end else begin
						state_q <= B_SUM;
					end
				end
				B_SUM: state_q <= B_DIV;
				B_DIV: state_q <= B_FIN;
				B_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_yaw_q   <= fin_yaw;
						out_roll_q  <= fin_roll;
						out_pitch_q <= PITCH_W'(fin_pitch);
						if (!raw_q) begin
							held_q  <= fin_pitch;
							known_q <= 1'b1;
						end
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_RING) begin
			ring_roll_q[next_slot]  <= roll_a;
			ring_pitch_q[next_slot] <= pitch_a;
			ring_yaw_q[next_slot]   <= yaw_a;
		end
		if (state_q == B_SUM) begin
			rs_q <= rs_c;
			ps_q <= ps_c;
			ys_q <= ys_c;
		end
		if (state_q == B_DIV) begin
			mroll_q  <= div_window(rs_q);
			mpitch_q <= div_window(ps_q);
			myaw_q   <= div_window(ys_q);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_SUM) |-> (fill_q == FILL_W'(WINDOW_SIZE)))
		else $error("window average taken before the ring is full");

	assert property (@(posedge clk) disable iff (!arst_n)
		known_q |-> (held_q <= HALF_PI_UNITS && held_q >= -HALF_PI_UNITS))
		else $error("held pitch outside plus or minus half pi");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_yaw_q <= PI_UNITS && out_yaw_q >= -PI_UNITS))
		else $error("yaw result not wrapped");

endmodule

@@ test/qes_tb_if.sv @@
// Testbench-side note: channel interfaces come from the design file qes_if.sv.
`timescale 1ns / 100ps
package qes_tb_pkg;
	typedef enum logic {
		OP_RAW_OFF = 1'b0,
		OP_RAW_ON  = 1'b1
	} raw_sel_t;
endpackage

@@ test/quaternion_euler_smoother_unit_test.sv @@
// Self-checking testbench of the quaternion to Euler angle smoother.
`timescale 1ns / 100ps
module quaternion_euler_smoother_unit_test;
	import qes_pkg::*;
	import qes_tb_pkg::*;

	localparam longint PI_U = PI_UNITS_L;
	localparam int CYCLE_LIMIT = 1500000;

	logic clk;
	logic arst_n;
	int unsigned errors = 0;
	longint unsigned cycles = 0;

	qes_quat_if  quat ();
	qes_cfg_if   cfg ();
	qes_euler_if euler ();

	quaternion_euler_smoother_unit u_dut (
		.clk(clk), .arst_n(arst_n), .quat(quat), .cfg(cfg), .euler(euler)
	);

	typedef struct {
		longint yaw;
		longint pitch;
		longint roll;
	} euler_t;

	// Print one mismatch line and count it.
	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("MISMATCH %s: got %0d, expected %0d at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	// Angle predictor: holds its own copy of the window state and registers.
	class euler_scoreboard;
		bit     raw_on;
		longint pitch_step;
		longint ring_roll[WINDOW_SIZE];
		longint ring_pitch[WINDOW_SIZE];
		longint ring_yaw[WINDOW_SIZE];
		int     slot;
		int     filled;
		longint held;
		bit     held_valid;
		euler_t pending[$];

		function new();
			raw_on = 0;
			pitch_step = MAX_STEP_RESET;
			foreach (ring_roll[i]) begin
				ring_roll[i] = 0;
				ring_pitch[i] = 0;
				ring_yaw[i] = 0;
			end
			slot = WINDOW_SIZE - 1;
			filled = 0;
			held = 0;
			held_valid = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [MAX_STEP_W-1:0] val);
			if (idx == CFG_RAW_MODE)
				raw_on = val[0];
			else if (idx == CFG_MAX_PITCH_STEP)
				pitch_step = val;
		endfunction

		static function longint angle_step(int i);
			longint t[31] = '{
				64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
				64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
				64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
				64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
				64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
				64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
				64'h00000001};
			return t[i];
		endfunction

		// Vectoring rotation, result in Q30 radians.
		static function longint vector_angle(longint y, longint x);
			longint base, z, mx, dx, dy;
			base = 0;
			z = 0;
			if (y == 0)
				return (x < 0) ? PI_Q30 : 0;
			if (x == 0)
				return (y > 0) ? HALF_PI_Q30 : -HALF_PI_Q30;
			if (x < 0) begin
				base = (y > 0) ? PI_Q30 : -PI_Q30;
				x = -x;
				y = -y;
			end
			mx = (x > ((y < 0) ? -y : y)) ? x : ((y < 0) ? -y : y);
			while (mx < (64'sd1 <<< 39)) begin
				x = x * 2;
				y = y * 2;
				mx = mx * 2;
			end
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (y > 0) begin
					x += dx; y -= dy; z += angle_step(i);
				end else begin
					x -= dx; y += dy; z -= angle_step(i);
				end
			end
			return base + z;
		endfunction

		static function longint q30_to_units(longint a);
			longint r;
			r = (a + (64'sd1 <<< (UNIT_SHIFT - 1))) >>> UNIT_SHIFT;
			if (r > PI_U) r = PI_U;
			if (r < -PI_U) r = -PI_U;
			return r;
		endfunction

		static function longint floor_root(longint unsigned v);
			longint unsigned res, b;
			res = 0;
			b = 64'd1 << 62;
			while (b > v) b = b >> 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v = v - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
			return res;
		endfunction

		// Mean over the window, rounded to nearest, ties away from zero.
		static function longint window_mean(longint v);
			longint m, q;
			m = (v < 0) ? -v : v;
			q = (m * 2 + WINDOW_SIZE) / (2 * WINDOW_SIZE);
			return (v < 0) ? -q : q;
		endfunction

		// Note one accepted quaternion; queue the angles it should produce.
		function void note_sample(longint w, longint x, longint y, longint z);
			longint n, m, am, nn, sm, rs, ps, ys, v, np, ny, lim;
			euler_t e;
			n = w * w + x * x + y * y + z * z;
			if (n == 0)
				return;   // drop the zero quaternion
			e.roll = q30_to_units(vector_angle(2 * (y * z - w * x),
				w * w - x * x - y * y + z * z));
			e.yaw = q30_to_units(vector_angle(2 * (x * y - w * z),
				w * w + x * x - y * y - z * z));
			m = 2 * (x * z + w * y);
			nn = (n >= (64'sd1 <<< 31)) ? (n >>> 1) : n;
			am = (m < 0) ? -m : m;
			if (n >= (64'sd1 <<< 31)) am = am >>> 1;
			if (am > nn) am = nn;
			sm = (m < 0) ? am : -am;
			e.pitch = q30_to_units(vector_angle(sm, floor_root((nn - am) * (nn + am))));
			if (!raw_on) begin
				slot = (slot + 1 >= WINDOW_SIZE) ? 0 : slot + 1;
				ring_roll[slot] = e.roll;
				ring_pitch[slot] = e.pitch;
				ring_yaw[slot] = e.yaw;
				if (filled < WINDOW_SIZE) begin
					filled++;
					return;
				end
				rs = 0; ps = 0; ys = 0;
				for (int j = 0; j < WINDOW_SIZE; j++) begin
					v = ring_yaw[j];
					rs += ring_roll[j];
					ps += ring_pitch[j];
					if (j != slot && ((ring_yaw[slot] - v > PI_U) || (v - ring_yaw[slot] > PI_U)))
						v += (ring_yaw[slot] > 0) ? 2 * PI_U : -2 * PI_U;
					ys += v;
				end
				e.roll = window_mean(rs);
				np = window_mean(ps);
				ny = window_mean(ys);
				if (ny > PI_U) ny -= 2 * PI_U;
				else if (ny < -PI_U) ny += 2 * PI_U;
				e.yaw = ny;
				if (!held_valid) begin
					held = np;
					held_valid = 1;
				end else if (np < held) begin
					lim = held - pitch_step;
					held = (np > lim) ? np : lim;
				end else if (np > held) begin
					lim = held + pitch_step;
					held = (np < lim) ? np : lim;
				end
				e.pitch = held;
			end
			pending.push_back(e);
		endfunction

		// Compare one accepted result with the oldest expected angles.
		task check_result(longint yaw, longint pitch, longint roll);
			euler_t e;
			if (pending.size() == 0) begin
				report_mismatch("unexpected result, yaw_angle", yaw, 0);
				return;
			end
			e = pending.pop_front();
			if (yaw != e.yaw) report_mismatch("yaw_angle", yaw, e.yaw);
			if (pitch != e.pitch) report_mismatch("pitch_angle", pitch, e.pitch);
			if (roll != e.roll) report_mismatch("roll_angle", roll, e.roll);
		endtask
	endclass

	euler_scoreboard sb;
	bit idle_on;          // random idling enabled
	bit hold_off;         // long receiver stall

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// Count cycles and end the run at the limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Watch both channels at each edge: note inputs, check results.
	always @(posedge clk) begin
		if (arst_n && quat.valid && quat.ready)
			sb.note_sample(quat.quat_w, quat.quat_x, quat.quat_y, quat.quat_z);
		if (arst_n && euler.valid && euler.ready)
			sb.check_result(euler.yaw_angle, euler.pitch_angle, euler.roll_angle);
	end

	// Receiver: ready with random stall bursts, or held low during a hold-off.
	initial begin : receiver
		int gap;
		euler.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				euler.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				gap = $urandom_range(1, 13);
				euler.ready <= 1'b0;
				repeat (gap - 1) @(posedge clk);
			end else begin
				euler.ready <= 1'b1;
			end
		end
	end

	// Offer one quaternion and hold it until accepted; idle first at random.
	task automatic send_quat(input logic [15:0] w, x, y, z);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			quat.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		quat.valid <= 1'b1;
		quat.quat_w <= w;
		quat.quat_x <= x;
		quat.quat_y <= y;
		quat.quat_z <= z;
		do @(posedge clk); while (!quat.ready);
	endtask

	task automatic release_quat();
		quat.valid <= 1'b0;
	endtask

	// Wait until every expected result is in, then let the pipeline drain.
	task automatic wait_drained();
		release_quat();
		do @(posedge clk); while (sb.pending.size() != 0);
		repeat (150) @(posedge clk);
	endtask

	// Write one register through the configuration channel (idle block only).
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MAX_STEP_W-1:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		sb.write_reg(idx, val);
		cfg.valid <= 1'b0;
	endtask

	// Random quaternion: mostly near a fixed attitude, some full-range noise.
	task automatic send_random();
		logic [15:0] c[4];
		int kind;
		kind = $urandom_range(0, 9);
		foreach (c[i]) begin
			if (kind < 2)
				c[i] = 16'($urandom());
			else if (kind < 3)
				c[i] = $urandom_range(0, 3) == 0 ? 16'h8000 : 16'(int'($urandom_range(0, 6)) - 3);
			else
				c[i] = 16'(int'($urandom_range(0, 4000)) - 2000 + (i == 0 ? 20000 : 0));
		end
		if ($urandom_range(0, 40) == 0)
			c = '{16'h0, 16'h0, 16'h0, 16'h0};
		send_quat(c[0], c[1], c[2], c[3]);
	endtask

	initial begin : stimulus
		raw_sel_t mode;
		logic [15:0] edge_vals[6] = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h5A82};
		sb = new();
		idle_on = 1;
		hold_off = 0;
		arst_n = 1'b0;
		quat.valid <= 1'b0;
		quat.quat_w <= '0; quat.quat_x <= '0; quat.quat_y <= '0; quat.quat_z <= '0;
		cfg.valid <= 1'b0;
		cfg.index <= '0;
		cfg.data <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: axis cases, extremes, zero quaternion, yaw near +-pi.
		mode = OP_RAW_ON;
		write_reg(CFG_RAW_MODE, 17'(mode));
		send_quat(16'h7FFF, 0, 0, 0);
		send_quat(0, 16'h7FFF, 0, 0);
		send_quat(0, 0, 16'h8000, 0);
		send_quat(0, 0, 0, 16'h7FFF);
		send_quat(0, 0, 0, 0);
		send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_quat(16'h5A82, 0, 16'h5A82, 0);
		send_quat(16'h5A82, 0, 16'hA57E, 0);
		send_quat(1, 0, 0, 0);
		send_quat(16'hFFFF, 1, 16'hFFFF, 1);
		wait_drained();
		mode = OP_RAW_OFF;
		write_reg(CFG_RAW_MODE, 17'(mode) | 17'h2);  // upper bits ignored
		write_reg(CFG_MAX_PITCH_STEP, 17'h1FFFF);
		// yaw straddles +-pi so the window unwraps
		send_quat(16'h0100, 0, 0, 16'h7F00);
		send_quat(16'hFF00, 0, 0, 16'h7F00);
		send_quat(16'h0200, 0, 0, 16'h7F00);
		send_quat(16'hFE00, 0, 0, 16'h7F00);
		send_quat(0, 0, 0, 0);
		send_quat(16'h5A82, 0, 16'h5A82, 0);
		send_quat(16'h5A82, 0, 16'hA57E, 0);
		wait_drained();
		write_reg(CFG_MAX_PITCH_STEP, 0);
		foreach (edge_vals[i]) send_quat(edge_vals[i], edge_vals[5 - i], edge_vals[i], 16'h7FFF);
		wait_drained();

		// Random phases through several register settings.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: write_reg(CFG_MAX_PITCH_STEP, MAX_STEP_RESET);
				1: write_reg(CFG_MAX_PITCH_STEP, 17'd102944);
				2: write_reg(CFG_RAW_MODE, 17'(OP_RAW_ON));
				3: begin
					write_reg(CFG_RAW_MODE, 17'(OP_RAW_OFF));
					write_reg(CFG_MAX_PITCH_STEP, 17'd1);
				end
				4: write_reg(CFG_MAX_PITCH_STEP, 17'($urandom_range(0, 131071)));
				default: write_reg(CFG_MAX_PITCH_STEP, 17'($urandom_range(0, 3000)));
			endcase
			if (ph == 5) idle_on = 0;   // final stretch without idling
			if (ph == 1) begin
				// Stall the receiver long enough for the block to back up its input.
				fork
					begin
						hold_off = 1;
						repeat (600) @(posedge clk);
						hold_off = 0;
					end
				join_none
			end
			for (int k = 0; k < 120; k++) send_random();
			wait_drained();
		end

		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

@@ files.f @@
design/qes_pkg.sv
design/qes_if.sv
design/qes_queue.sv
design/qes_front.sv
design/qes_cordic.sv
design/qes_back.sv
design/quaternion_euler_smoother_unit.sv
test/qes_tb_if.sv
test/quaternion_euler_smoother_unit_test.sv
